[rtl/core/crc8fp_pkg.sv]
// Shared types, constants and CRC-8 helper for the CRC-8 frame parser.
package crc8fp_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int PAY_AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [7:0] LEN_MAX = 8'(MAX_PAYLOAD);

    localparam logic [7:0] CRC_POLY    = 8'h31;
    localparam logic [7:0] SYNC_RESET  = 8'hAA;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_ERR   = 2'd1;
    localparam logic [1:0] ST_READY = 2'd2;

    localparam logic CFG_SYNC    = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] sys_id;
        logic [7:0] dest_id;
        logic [7:0] msg_id;
        logic [6:0] payload_len;
        logic       wr;
        logic [7:0] data;
        logic [5:0] idx;
    } entry_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] sys_id;
        logic [7:0] dest_id;
        logic [7:0] msg_id;
        logic [6:0] payload_len;
        logic       has_byte;
        logic [7:0] payload_byte;
        logic [5:0] byte_index;
        logic       last;
    } result_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[rtl/core/crc8fp_front.sv]
// Front end: sync hunt, header/payload tracking, running CRC and timeout.
module crc8fp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            rx_byte,
    input  logic [31:0]           now_ms,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [31:0]           cfg_data,
    output logic                  push_valid,
    input  logic                  push_ready,
    output crc8fp_pkg::entry_t    push_data
);
    import crc8fp_pkg::*;

    localparam logic [1:0] FS_HUNT   = 2'd0;
    localparam logic [1:0] FS_HEADER = 2'd1;
    localparam logic [1:0] FS_DATA   = 2'd2;
    localparam logic [1:0] FS_CRC    = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  sys_reg, sys_next;
    logic [7:0]  tgt_reg, tgt_next;
    logic [7:0]  msg_reg, msg_next;
    logic [7:0]  crc_reg, crc_next;
    logic [31:0] last_time_reg, last_time_next;
    logic [7:0]  sync_reg, sync_next;
    logic [31:0] timeout_reg, timeout_next;

    logic        accept;
    logic        start;
    logic        to_hit;
    logic [31:0] gap;
    logic [1:0]  eff_state;
    entry_t      entry;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign push_data  = entry;
    assign accept     = in_valid && push_ready;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        sys_next       = sys_reg;
        tgt_next       = tgt_reg;
        msg_next       = msg_reg;
        crc_next       = crc_reg;
        last_time_next = last_time_reg;
        sync_next      = sync_reg;
        timeout_next   = timeout_reg;
        entry          = '0;
        start          = 1'b0;

        gap       = now_ms - last_time_reg;
        to_hit    = (timeout_reg != 32'd0) && (gap > timeout_reg) && (state_reg != FS_HUNT);
        eff_state = to_hit ? FS_HUNT : state_reg;

        if (accept)
        begin
            unique case (eff_state)
                FS_HUNT:
                begin
                    state_next = FS_HUNT;
                    if (rx_byte == sync_reg)
                    begin
                        state_next = FS_HEADER;
                        pos_next   = '0;
                        crc_next   = '0;
                        start      = 1'b1;
                    end
                end
                FS_HEADER:
                begin
                    crc_next = crc8_update(crc_reg, rx_byte);
                    pos_next = pos_reg + 6'd1;
                    unique case (pos_reg[1:0])
                        2'd0:    len_next = rx_byte;
                        2'd1:    sys_next = rx_byte;
                        2'd2:    tgt_next = rx_byte;
                        default: msg_next = rx_byte;
                    endcase
                    if (pos_reg == 6'd3)
                    begin
                        pos_next = '0;
                        if (len_reg > LEN_MAX)
                        begin
                            entry.status = ST_ERR;
                            state_next   = FS_HUNT;
                        end
                        else if (len_reg == 8'd0)
                            state_next = FS_CRC;
                        else
                            state_next = FS_DATA;
                    end
                end
                FS_DATA:
                begin
                    crc_next   = crc8_update(crc_reg, rx_byte);
                    entry.wr   = 1'b1;
                    entry.data = rx_byte;
                    entry.idx  = pos_reg;
                    pos_next   = pos_reg + 6'd1;
                    if (({1'b0, pos_reg} + 7'd1) == len_reg[6:0])
                        state_next = FS_CRC;
                end
                default:
                begin
                    state_next = FS_HUNT;
                    if (rx_byte == crc_reg)
                    begin
                        entry.status      = ST_READY;
                        entry.sys_id      = sys_reg;
                        entry.dest_id     = tgt_reg;
                        entry.msg_id      = msg_reg;
                        entry.payload_len = len_reg[6:0];
                    end
                    else
                        entry.status = ST_ERR;
                end
            endcase
            if (timeout_reg != 32'd0)
                last_time_next = now_ms;
            else if (start)
                last_time_next = '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC: sync_next = cfg_data[7:0];
                default:
                begin
                    timeout_next = cfg_data;
                    if (state_reg != FS_HUNT)
                    begin
                        state_next     = FS_HUNT;
                        last_time_next = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FS_HUNT;
            pos_reg       <= '0;
            len_reg       <= '0;
            crc_reg       <= '0;
            last_time_reg <= '0;
            sync_reg      <= SYNC_RESET;
            timeout_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            crc_reg       <= crc_next;
            last_time_reg <= last_time_next;
            sync_reg      <= sync_next;
            timeout_reg   <= timeout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sys_reg <= sys_next;
        tgt_reg <= tgt_next;
        msg_reg <= msg_next;
    end

endmodule

[rtl/core/crc8fp_queue.sv]
// Small FIFO between the front end and the result back end.
module crc8fp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  crc8fp_pkg::entry_t    push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output crc8fp_pkg::entry_t    pop_data
);
    import crc8fp_pkg::*;

    localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QDEPTH);
    localparam logic [QPTR_W-1:0] QLAST = QPTR_W'(QDEPTH - 1);

    entry_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != QFULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = q_mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QLAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QLAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QFULL)
        else $error("queue count above depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QFULL) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

[rtl/core/crc8fp_back.sv]
// Back end: payload buffer, result burst sequencer and output register.
module crc8fp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  crc8fp_pkg::entry_t    pop_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output crc8fp_pkg::result_t   out_data
);
    import crc8fp_pkg::*;

    localparam logic B_IDLE  = 1'b0;
    localparam logic B_BURST = 1'b1;

    logic [7:0]        pay_mem [MAX_PAYLOAD];
    logic [7:0]        rdata_reg;
    logic [PAY_AW-1:0] rd_addr;

    logic              state_reg, state_next;
    logic [5:0]        cnt_reg, cnt_next;
    entry_t            hdr_reg, hdr_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic              slot_free;
    logic              pop;
    logic              mem_we;
    logic              burst_last;

    assign slot_free  = !out_valid_reg || out_ready;
    assign pop_ready  = (state_reg == B_IDLE) && slot_free;
    assign pop        = pop_ready && pop_valid;
    assign burst_last = (({1'b0, cnt_reg} + 7'd1) == hdr_reg.payload_len);
    assign rd_addr    = cnt_next[PAY_AW-1:0];
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        hdr_next       = hdr_reg;
        out_next       = out_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        mem_we         = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    mem_we = pop_data.wr;
                    if (pop_data.status == ST_READY && pop_data.payload_len != 7'd0)
                    begin
                        state_next = B_BURST;
                        cnt_next   = '0;
                        hdr_next   = pop_data;
                    end
                    else
                    begin
                        out_valid_next       = 1'b1;
                        out_next.status      = pop_data.status;
                        out_next.sys_id      = pop_data.sys_id;
                        out_next.dest_id     = pop_data.dest_id;
                        out_next.msg_id      = pop_data.msg_id;
                        out_next.payload_len = pop_data.payload_len;
                        out_next.has_byte    = 1'b0;
                        out_next.payload_byte = '0;
                        out_next.byte_index  = '0;
                        out_next.last        = 1'b1;
                    end
                end
            end
            default:
            begin
                if (slot_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.status       = ST_READY;
                    out_next.sys_id       = hdr_reg.sys_id;
                    out_next.dest_id      = hdr_reg.dest_id;
                    out_next.msg_id       = hdr_reg.msg_id;
                    out_next.payload_len  = hdr_reg.payload_len;
                    out_next.has_byte     = 1'b1;
                    out_next.payload_byte = rdata_reg;
                    out_next.byte_index   = cnt_reg;
                    out_next.last         = burst_last;
                    if (burst_last)
                        state_next = B_IDLE;
                    else
                        cnt_next = cnt_reg + 6'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            pay_mem[pop_data.idx[PAY_AW-1:0]] <= pop_data.data;
        rdata_reg <= pay_mem[rd_addr];
    end

    a_burst_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_BURST |-> ({1'b0, cnt_reg} < hdr_reg.payload_len))
        else $error("burst index past payload length");

    a_byte_only_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.has_byte) |-> out_reg.status == ST_READY)
        else $error("payload byte on a non-ready result");

    a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_BURST && slot_free && burst_last) |=>
            (state_reg == B_IDLE && out_valid_reg && out_reg.last))
        else $error("burst did not close with a last result");

    a_no_write_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_BURST |-> !mem_we)
        else $error("payload buffer written during burst");

endmodule

[rtl/core/crc8_frame_parser_timeout_top.sv]
// Top level of the sync/length/CRC-8 frame parser with inter-byte timeout.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------------
//  input    | in_valid / in_ready      | rx_byte, now_ms
//  output   | out_valid / out_ready    | status, sys_id, dest_id, msg_id,
//           |                          | payload_len, has_byte, payload_byte,
//           |                          | byte_index, last
//  config   | cfg_we                   | cfg_index, cfg_data
//
// Front end takes one item per cycle while the 4-entry queue has room.
// Back end retires one queue entry per cycle unless the output stalls; a good frame
// with LEN > 0 holds it while the payload buffer is read out, one result per cycle
// unless stalled. A result passes the queue, then the output register; a burst adds
// the payload buffer read register. Reset is asynchronous, active low; no clearing
// pass is needed. Output stalls back up through the queue to in_ready.
module crc8_frame_parser_timeout_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  sys_id,
    output logic [7:0]  dest_id,
    output logic [7:0]  msg_id,
    output logic [6:0]  payload_len,
    output logic        has_byte,
    output logic [7:0]  payload_byte,
    output logic [5:0]  byte_index,
    output logic        last,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import crc8fp_pkg::*;

    logic    push_valid;
    logic    push_ready;
    entry_t  push_data;
    logic    pop_valid;
    logic    pop_ready;
    entry_t  pop_data;
    result_t res;

    crc8fp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .now_ms     (now_ms),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    crc8fp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    crc8fp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (res)
    );

    assign status       = res.status;
    assign sys_id       = res.sys_id;
    assign dest_id      = res.dest_id;
    assign msg_id       = res.msg_id;
    assign payload_len  = res.payload_len;
    assign has_byte     = res.has_byte;
    assign payload_byte = res.payload_byte;
    assign byte_index   = res.byte_index;
    assign last         = res.last;

endmodule
